>>> rtl/mesh_vertex_plane_contact_macros.svh
// Assertion macros shared by the RTL of the vertex-plane contact block.
// The implication forms take a clock, a synchronous reset, an antecedent and a consequent.
`ifndef MESH_VERTEX_PLANE_CONTACT_MACROS_SVH
`define MESH_VERTEX_PLANE_CONTACT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define MVPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mvpc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MVPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mvpc assertion failed");

`else

`define MVPC_ASSERT_SAME(label, clk, rst, ante, cons)

`define MVPC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/mvpc_pkg.sv
`timescale 1ns / 1ps

package mvpc_pkg;

   // Number formats: positions Q5.16, rotation and normal entries Q1.12.
   localparam int POS_W     = 22;
   localparam int ROT_W     = 14;
   localparam int FRAC_ROT  = 12;
   localparam int EPS_W     = 21;
   localparam int REG_W     = 64;
   localparam int CSR_ADDR_W = 6;

   localparam int POS_MAX    = (1 << (POS_W - 1)) - 1;
   localparam int POS_MIN    = -(1 << (POS_W - 1));
   localparam int ROUND_HALF = 1 << (FRAC_ROT - 1);

   // Internal widths, chosen to hold every intermediate exactly.
   localparam int PROD_W = 36;   // rotation entry times position
   localparam int ACC_W  = 40;   // three products plus shifted translation
   localparam int LOC_W  = 28;   // rounded transformed coordinate
   localparam int DP_W   = 42;   // normal entry times coordinate
   localparam int DOT_W  = 46;   // sum of three such products
   localparam int DIST_W = 34;   // signed distance
   localparam int NDP_W  = 48;   // normal entry times distance
   localparam int SAT_W  = 40;   // input width of the saturation function

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 160;

   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic signed [LOC_W-1:0]  loc_type;
   typedef logic signed [DP_W-1:0]   dp_type;
   typedef logic signed [DOT_W-1:0]  dot_type;
   typedef logic signed [DIST_W-1:0] dist_type;
   typedef logic signed [NDP_W-1:0]  ndp_type;
   typedef logic signed [SAT_W-1:0]  sat_type;

   // One pose row or the normal/offset register, as laid out in the register.
   typedef struct packed {
      logic [POS_W-1:0] trans;
      logic [ROT_W-1:0] rot_z;
      logic [ROT_W-1:0] rot_y;
      logic [ROT_W-1:0] rot_x;
   } pose_row_type;

   // Register indexes.
   typedef logic [2:0] reg_idx_type;
   localparam reg_idx_type REG_PLANE_ROW0 = 3'd0;
   localparam reg_idx_type REG_PLANE_ROW1 = 3'd1;
   localparam reg_idx_type REG_PLANE_ROW2 = 3'd2;
   localparam reg_idx_type REG_NORMAL     = 3'd3;
   localparam reg_idx_type REG_MESH_ROW0  = 3'd4;
   localparam reg_idx_type REG_MESH_ROW1  = 3'd5;
   localparam reg_idx_type REG_MESH_ROW2  = 3'd6;
   localparam reg_idx_type REG_EPSILON    = 3'd7;

   // Load enables of the six pipeline register sets.
   typedef struct packed {
      logic s6;
      logic s5;
      logic s4;
      logic s3;
      logic s2;
      logic s1;
   } pipe_adv_type;

   localparam sat_type SAT_HI = SAT_W'(POS_MAX);
   localparam sat_type SAT_LO = SAT_W'(POS_MIN);
   localparam pos_type POS_HI = POS_W'(POS_MAX);
   localparam pos_type POS_LO = POS_W'(POS_MIN);

   // Clamp a wide signed value to the position range.
   function automatic pos_type sat_pos(input sat_type x);
      pos_type r;
      if (x > SAT_HI) begin
         r = POS_HI;
      end else if (x < SAT_LO) begin
         r = POS_LO;
      end else begin
         r = x[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/mvpc_xform.sv
`timescale 1ns / 1ps

module mvpc_xform (
   input  logic                   clock,
   input  mvpc_pkg::pipe_adv_type adv,
   input  mvpc_pkg::pose_row_type row [3],
   input  mvpc_pkg::pos_type      vertex [3],
   output mvpc_pkg::loc_type      loc [3]
);
   import mvpc_pkg::*;

   prod_type prod_ff [3][3];
   prod_type prod_in [3][3];
   loc_type  loc_ff [3];
   loc_type  loc_in [3];

   for (genvar r = 0; r < 3; r++) begin : g_row
      acc_type acc;

      // First stage: the three products of this row.
      always_comb begin
         prod_in[r][0] = PROD_W'($signed(row[r].rot_x)) * PROD_W'(vertex[0]);
         prod_in[r][1] = PROD_W'($signed(row[r].rot_y)) * PROD_W'(vertex[1]);
         prod_in[r][2] = PROD_W'($signed(row[r].rot_z)) * PROD_W'(vertex[2]);
      end

      // Second stage: sum with the translation and round half up to Q16.
      always_comb begin
         acc = ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1]) + ACC_W'(prod_ff[r][2])
             + (ACC_W'($signed(row[r].trans)) <<< FRAC_ROT) + ACC_W'(ROUND_HALF);
         loc_in[r] = acc[FRAC_ROT +: LOC_W];
      end
   end

   // Pipeline registers of both stages.
   always_ff @(posedge clock) begin
      if (adv.s1) begin
         prod_ff <= prod_in;
      end
      if (adv.s2) begin
         loc_ff <= loc_in;
      end
   end

   assign loc = loc_ff;

endmodule

>>> rtl/mvpc_dist.sv
`timescale 1ns / 1ps

module mvpc_dist (
   input  logic                     clock,
   input  mvpc_pkg::pipe_adv_type   adv,
   input  mvpc_pkg::pose_row_type   nrm,
   input  logic [mvpc_pkg::EPS_W-1:0] eps,
   input  mvpc_pkg::loc_type        p_in [3],
   output mvpc_pkg::loc_type        p_out [3],
   output mvpc_pkg::dist_type       d_out,
   output logic                     contact
);
   import mvpc_pkg::*;

   dp_type   np_ff [3];
   dp_type   np_in [3];
   loc_type  p3_ff [3];
   loc_type  p4_ff [3];
   dist_type d_ff;
   dist_type d_in;
   logic     contact_ff;
   logic     contact_in;
   dot_type  dot;
   dist_type eps_s;

   // Third stage: normal entries times the plane-local coordinates.
   always_comb begin
      np_in[0] = DP_W'($signed(nrm.rot_x)) * DP_W'(p_in[0]);
      np_in[1] = DP_W'($signed(nrm.rot_y)) * DP_W'(p_in[1]);
      np_in[2] = DP_W'($signed(nrm.rot_z)) * DP_W'(p_in[2]);
   end

   // Fourth stage: round the dot product, add the offset and test against epsilon.
   always_comb begin
      dot = DOT_W'(np_ff[0]) + DOT_W'(np_ff[1]) + DOT_W'(np_ff[2]) + DOT_W'(ROUND_HALF);
      d_in = dot[FRAC_ROT +: DIST_W] + DIST_W'($signed(nrm.trans));
      eps_s = DIST_W'({1'b0, eps});
      contact_in = d_in < eps_s;
   end

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         np_ff <= np_in;
         p3_ff <= p_in;
      end
      if (adv.s4) begin
         d_ff       <= d_in;
         contact_ff <= contact_in;
         p4_ff      <= p3_ff;
      end
   end

   assign p_out   = p4_ff;
   assign d_out   = d_ff;
   assign contact = contact_ff;

endmodule

>>> rtl/mvpc_proj.sv
`timescale 1ns / 1ps

module mvpc_proj (
   input  logic                   clock,
   input  mvpc_pkg::pipe_adv_type adv,
   input  mvpc_pkg::pose_row_type nrm,
   input  mvpc_pkg::dist_type     d_in,
   input  mvpc_pkg::loc_type      p_in [3],
   input  mvpc_pkg::loc_type      m_in [3],
   output mvpc_pkg::pos_type      depth,
   output mvpc_pkg::pos_type      mesh_local [3],
   output mvpc_pkg::pos_type      plane_point [3]
);
   import mvpc_pkg::*;

   ndp_type nd_ff [3];
   ndp_type nd_in [3];
   loc_type p5_ff [3];
   pos_type depth5_ff;
   pos_type mesh5_ff [3];
   pos_type mesh5_in [3];
   pos_type depth_ff;
   pos_type mesh_ff [3];
   pos_type plane_ff [3];
   pos_type plane_in [3];
   ndp_type nd_round [3];

   // Fifth stage: normal times distance, depth and mesh-local saturation.
   always_comb begin
      nd_in[0] = NDP_W'($signed(nrm.rot_x)) * NDP_W'(d_in);
      nd_in[1] = NDP_W'($signed(nrm.rot_y)) * NDP_W'(d_in);
      nd_in[2] = NDP_W'($signed(nrm.rot_z)) * NDP_W'(d_in);
      for (int unsigned i = 0; i < 3; i++) begin
         mesh5_in[i] = sat_pos(SAT_W'(m_in[i]));
      end
   end

   // Sixth stage: subtract the rounded normal component and saturate.
   always_comb begin
      for (int unsigned i = 0; i < 3; i++) begin
         nd_round[i] = nd_ff[i] + NDP_W'(ROUND_HALF);
         plane_in[i] = sat_pos(SAT_W'(p5_ff[i])
                             - SAT_W'($signed(nd_round[i][NDP_W-1:FRAC_ROT])));
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s5) begin
         nd_ff     <= nd_in;
         p5_ff     <= p_in;
         depth5_ff <= sat_pos(-SAT_W'(d_in));
         mesh5_ff  <= mesh5_in;
      end
      if (adv.s6) begin
         depth_ff <= depth5_ff;
         mesh_ff  <= mesh5_ff;
         plane_ff <= plane_in;
      end
   end

   assign depth       = depth_ff;
   assign mesh_local  = mesh_ff;
   assign plane_point = plane_ff;

endmodule

>>> rtl/mesh_vertex_plane_contact.sv
// Vertex against plane contact test, six register stages deep.
// Requests pass the stages in order; each stage holds one multiply or one sum and round.
// Throughput: one request per cycle while rsp_tready does not stall the output.
// A request whose vertex does not touch the plane leaves the pipeline without a response.
// Synchronous active-high reset empties the pipeline and loads the register reset values.
`timescale 1ns / 1ps
`include "mesh_vertex_plane_contact_macros.svh"

module mesh_vertex_plane_contact (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // vertex_x, vertex_y, vertex_z (22 bits each), 6 pad bits
   input  logic [mvpc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // depth, mesh_local_x/y/z, plane_point_x/y/z (22 bits each), 6 pad bits
   output logic [mvpc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mvpc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mvpc_pkg::REG_W-1:0]          csr_pwdata,
   output logic [mvpc_pkg::REG_W-1:0]          csr_prdata,
   output logic                                csr_pready
);
   import mvpc_pkg::*;

   pose_row_type       plane_row_ff [3];
   pose_row_type       mesh_row_ff [3];
   pose_row_type       normal_ff;
   logic [EPS_W-1:0]   eps_ff;
   logic               wr_en;
   reg_idx_type        reg_idx;

   pipe_adv_type       adv;
   logic [5:0]         valid_ff;
   logic [5:0]         valid_in;
   logic               contact4;
   logic               contact5_ff;

   pos_type            vertex [3];
   loc_type            p_loc [3];
   loc_type            m_loc [3];
   loc_type            m3_ff [3];
   loc_type            m4_ff [3];
   loc_type            p4 [3];
   dist_type           d4;
   pos_type            depth;
   pos_type            mesh_local [3];
   pos_type            plane_point [3];

   // Register file writes.
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_row_ff[0] <= '0;
         plane_row_ff[1] <= '0;
         plane_row_ff[2] <= '0;
         mesh_row_ff[0]  <= '0;
         mesh_row_ff[1]  <= '0;
         mesh_row_ff[2]  <= '0;
         normal_ff       <= '0;
         eps_ff          <= EPS_W'(1);
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_PLANE_ROW0: plane_row_ff[0] <= pose_row_type'(csr_pwdata);
            REG_PLANE_ROW1: plane_row_ff[1] <= pose_row_type'(csr_pwdata);
            REG_PLANE_ROW2: plane_row_ff[2] <= pose_row_type'(csr_pwdata);
            REG_NORMAL:     normal_ff       <= pose_row_type'(csr_pwdata);
            REG_MESH_ROW0:  mesh_row_ff[0]  <= pose_row_type'(csr_pwdata);
            REG_MESH_ROW1:  mesh_row_ff[1]  <= pose_row_type'(csr_pwdata);
            REG_MESH_ROW2:  mesh_row_ff[2]  <= pose_row_type'(csr_pwdata);
            REG_EPSILON:    eps_ff          <= csr_pwdata[EPS_W-1:0];
         endcase
      end
   end

   // Register file reads.
   always_comb begin
      unique case (reg_idx)
         REG_PLANE_ROW0: csr_prdata = plane_row_ff[0];
         REG_PLANE_ROW1: csr_prdata = plane_row_ff[1];
         REG_PLANE_ROW2: csr_prdata = plane_row_ff[2];
         REG_NORMAL:     csr_prdata = normal_ff;
         REG_MESH_ROW0:  csr_prdata = mesh_row_ff[0];
         REG_MESH_ROW1:  csr_prdata = mesh_row_ff[1];
         REG_MESH_ROW2:  csr_prdata = mesh_row_ff[2];
         REG_EPSILON:    csr_prdata = REG_W'(eps_ff);
      endcase
   end

   // A stage loads when it is empty or when the stage after it loads.
   always_comb begin
      adv.s6 = !valid_ff[5] || rsp_tready;
      adv.s5 = !valid_ff[4] || adv.s6;
      adv.s4 = !valid_ff[3] || adv.s5;
      adv.s3 = !valid_ff[2] || adv.s4;
      adv.s2 = !valid_ff[1] || adv.s3;
      adv.s1 = !valid_ff[0] || adv.s2;
   end

   // Valid bits follow the data; a vertex without contact is dropped before the output.
   always_comb begin
      valid_in[0] = adv.s1 ? req_tvalid  : valid_ff[0];
      valid_in[1] = adv.s2 ? valid_ff[0] : valid_ff[1];
      valid_in[2] = adv.s3 ? valid_ff[1] : valid_ff[2];
      valid_in[3] = adv.s4 ? valid_ff[2] : valid_ff[3];
      valid_in[4] = adv.s5 ? valid_ff[3] : valid_ff[4];
      valid_in[5] = adv.s6 ? (valid_ff[4] && contact5_ff) : valid_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Mesh-local coordinates and the contact flag wait for the distance stages.
   always_ff @(posedge clock) begin
      if (adv.s3) begin
         m3_ff <= m_loc;
      end
      if (adv.s4) begin
         m4_ff <= m3_ff;
      end
      if (adv.s5) begin
         contact5_ff <= contact4;
      end
   end

   assign req_tready = adv.s1;
   assign rsp_tvalid = valid_ff[5];

   assign vertex[0] = req_tdata[POS_W-1:0];
   assign vertex[1] = req_tdata[2*POS_W-1:POS_W];
   assign vertex[2] = req_tdata[3*POS_W-1:2*POS_W];

   mvpc_xform u_plane_xform (
      .clock  (clock),
      .adv    (adv),
      .row    (plane_row_ff),
      .vertex (vertex),
      .loc    (p_loc)
   );

   mvpc_xform u_mesh_xform (
      .clock  (clock),
      .adv    (adv),
      .row    (mesh_row_ff),
      .vertex (vertex),
      .loc    (m_loc)
   );

   mvpc_dist u_dist (
      .clock   (clock),
      .adv     (adv),
      .nrm     (normal_ff),
      .eps     (eps_ff),
      .p_in    (p_loc),
      .p_out   (p4),
      .d_out   (d4),
      .contact (contact4)
   );

   mvpc_proj u_proj (
      .clock       (clock),
      .adv         (adv),
      .nrm         (normal_ff),
      .d_in        (d4),
      .p_in        (p4),
      .m_in        (m4_ff),
      .depth       (depth),
      .mesh_local  (mesh_local),
      .plane_point (plane_point)
   );

   assign rsp_tdata = {(RSP_DATA_W - 7 * POS_W)'(0),
                       plane_point[2], plane_point[1], plane_point[0],
                       mesh_local[2], mesh_local[1], mesh_local[0],
                       depth};

   // An empty pipeline always takes a request.
   `MVPC_ASSERT_SAME(a_empty_takes_request, clock, reset, valid_ff == 6'b0, req_tready)
   // A stalled distance result stays in its stage.
   `MVPC_ASSERT_NEXT(a_stall_keeps_item, clock, reset, valid_ff[3] && !adv.s5, valid_ff[3])
   // A contact that moves into the output register is offered as a response.
   `MVPC_ASSERT_NEXT(a_contact_reaches_output, clock, reset,
                     valid_ff[4] && contact5_ff && adv.s6, rsp_tvalid)

endmodule

>>> test/mesh_vertex_plane_contact_tb.sv
`timescale 1ns / 1ps

module mesh_vertex_plane_contact_tb;
   import mvpc_pkg::*;

   localparam int PIPE_DEPTH  = 6;
   localparam int MAX_WAIT    = 18;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 128;
   localparam int QUIET_LIMIT = 2000;
   localparam int ROT_MAX     = 8191;
   localparam int ROT_MIN     = -8192;
   localparam int UNIT        = 4096;

   // One contact as it travels on rsp_tdata, depth in the lowest slot.
   typedef logic [6:0][POS_W-1:0] contact_word_type;

   // One row of the directed table: a register write or a vertex request.
   typedef struct {
      bit               is_write;
      reg_idx_type      idx;
      logic [REG_W-1:0] value;
      pos_type          vx;
      pos_type          vy;
      pos_type          vz;
      bit               typed;
      bit               hit;
      contact_word_type want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [REG_W-1:0]      csr_pwdata;
   logic [REG_W-1:0]      csr_prdata;
   logic                  csr_pready;

   // Shadow copy of the register file, updated on every write.
   logic [REG_W-1:0] csr_shadow [8];
   contact_word_type expected_contacts [$];
   stim_row_type     directed_rows [$];
   string            field_label [7] = '{"depth", "mesh_local_x", "mesh_local_y",
                                         "mesh_local_z", "plane_point_x",
                                         "plane_point_y", "plane_point_z"};

   bit sender_calm   = 1'b0;
   bit receiver_calm = 1'b0;
   int vertices_sent    = 0;
   int contacts_checked = 0;
   int csr_writes       = 0;
   int mismatches       = 0;
   int quiet_cycles     = 0;

   mesh_vertex_plane_contact dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Fixed-point helpers of the contact predictor.
   function automatic longint rot_entry(input logic [REG_W-1:0] r, input int k);
      logic signed [ROT_W-1:0] e;
      e = r[k*ROT_W +: ROT_W];
      return e;
   endfunction

   function automatic longint trans_entry(input logic [REG_W-1:0] r);
      logic signed [POS_W-1:0] t;
      t = r[3*ROT_W +: POS_W];
      return t;
   endfunction

   // Round half up from Q.28 to Q.16: floor((x + half) / 4096).
   function automatic longint round_q12(input longint x);
      return (x + ROUND_HALF) >>> FRAC_ROT;
   endfunction

   function automatic pos_type clamp_pos(input longint x);
      if (x > longint'(POS_MAX)) begin
         return pos_type'(POS_MAX);
      end
      if (x < longint'(POS_MIN)) begin
         return pos_type'(POS_MIN);
      end
      return pos_type'(x);
   endfunction

   function automatic longint apply_row(input logic [REG_W-1:0] r,
                                        input longint x, input longint y, input longint z);
      return round_q12(rot_entry(r, 0) * x + rot_entry(r, 1) * y + rot_entry(r, 2) * z
                       + (trans_entry(r) <<< FRAC_ROT));
   endfunction

   // Works out whether a vertex touches the plane and, if so, the contact it yields.
   function automatic bit predict_contact(input pos_type vx, input pos_type vy,
                                          input pos_type vz, output contact_word_type c);
      longint p [3];
      longint dot;
      longint dist_val;
      longint eps;
      c = '0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         p[i] = apply_row(csr_shadow[REG_PLANE_ROW0 + i], vx, vy, vz);
         dot += rot_entry(csr_shadow[REG_NORMAL], i) * p[i];
      end
      dist_val = round_q12(dot) + trans_entry(csr_shadow[REG_NORMAL]);
      eps      = csr_shadow[REG_EPSILON][EPS_W-1:0];
      if (!(dist_val < eps)) begin
         return 1'b0;
      end
      c[0] = clamp_pos(-dist_val);
      for (int i = 0; i < 3; i++) begin
         c[1+i] = clamp_pos(apply_row(csr_shadow[REG_MESH_ROW0 + i], vx, vy, vz));
         c[4+i] = clamp_pos(p[i] - round_q12(rot_entry(csr_shadow[REG_NORMAL], i) * dist_val));
      end
      return 1'b1;
   endfunction

   function automatic logic [REG_W-1:0] make_row(input int rx, input int ry, input int rz,
                                                 input int t);
      pose_row_type r;
      r.rot_x = rx[ROT_W-1:0];
      r.rot_y = ry[ROT_W-1:0];
      r.rot_z = rz[ROT_W-1:0];
      r.trans = t[POS_W-1:0];
      return r;
   endfunction

   function automatic contact_word_type contact_of(input int depth, input int mx, input int my,
                                                   input int mz, input int px, input int py,
                                                   input int pz);
      contact_word_type c;
      c[0] = pos_type'(depth);
      c[1] = pos_type'(mx);
      c[2] = pos_type'(my);
      c[3] = pos_type'(mz);
      c[4] = pos_type'(px);
      c[5] = pos_type'(py);
      c[6] = pos_type'(pz);
      return c;
   endfunction

   // Builders of the directed table.
   function automatic void add_write(input reg_idx_type idx, input logic [REG_W-1:0] value);
      stim_row_type r;
      r = '{default: 0};
      r.is_write = 1'b1;
      r.idx      = idx;
      r.value    = value;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_typed(input int x, input int y, input int z, input bit hit,
                                     input contact_word_type want);
      stim_row_type r;
      r = '{default: 0};
      r.vx    = pos_type'(x);
      r.vy    = pos_type'(y);
      r.vz    = pos_type'(z);
      r.typed = 1'b1;
      r.hit   = hit;
      r.want  = want;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_vertex(input int x, input int y, input int z);
      stim_row_type r;
      r = '{default: 0};
      r.vx = pos_type'(x);
      r.vy = pos_type'(y);
      r.vz = pos_type'(z);
      directed_rows.push_back(r);
   endfunction

   // A pose row for the random phases: fully random, signed axis, or all extremes.
   function automatic logic [REG_W-1:0] random_pose_row(input int mode, input int axis);
      int e [3];
      int t;
      if (mode == 0) begin
         return {$urandom, $urandom};
      end
      for (int k = 0; k < 3; k++) begin
         if (mode == 1) begin
            e[k] = (k != axis) ? 0 : ($urandom_range(0, 1) ? UNIT : -UNIT);
         end else begin
            e[k] = $urandom_range(0, 1) ? ROT_MAX : ROT_MIN;
         end
      end
      if (mode == 1) begin
         t = int'($urandom_range(0, 1 << 19)) - (1 << 18);
      end else begin
         t = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
      end
      return make_row(e[0], e[1], e[2], t);
   endfunction

   // Vertex coordinate mix: extremes, small magnitudes and the full range.
   function automatic pos_type pick_coord();
      case ($urandom_range(0, 9)) inside
         0: begin
            case ($urandom_range(0, 3))
               0: return pos_type'(POS_MAX);
               1: return pos_type'(POS_MIN);
               2: return '0;
               default: return '1;
            endcase
         end
         [1:3]: return pos_type'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
         default: return pos_type'($urandom);
      endcase
   endfunction

   // Offers one vertex request and returns at the edge where it is accepted.
   task automatic offer_vertex(input pos_type x, input pos_type y, input pos_type z);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({z, y, x});
      do @(posedge clock); while (!(req_tvalid && req_tready));
      vertices_sent++;
   endtask

   task automatic expect_predicted(input pos_type x, input pos_type y, input pos_type z);
      contact_word_type c;
      if (predict_contact(x, y, z, c)) begin
         expected_contacts.push_back(c);
      end
   endtask

   // Lets the pipeline empty before the registers change.
   task automatic settle_pipeline();
      req_tvalid <= 1'b0;
      while (expected_contacts.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   // Setup and access phases; the select stays high so writes can run back to back.
   task automatic write_csr(input reg_idx_type idx, input logic [REG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 3'b000});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_shadow[idx] = (idx == REG_EPSILON) ? REG_W'(value[EPS_W-1:0]) : value;
      csr_writes++;
   endtask

   task automatic release_csr();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Response side: random stalls, with calm stretches where it never stalls.
   initial begin : receiver
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         stall = receiver_calm ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Compares every accepted contact with the oldest expected one.
   always @(posedge clock) begin : check_contacts
      contact_word_type got;
      contact_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[7*POS_W-1:0];
         if (expected_contacts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("contact with none expected: %h", got);
            end
         end else begin
            want = expected_contacts.pop_front();
            contacts_checked++;
            for (int f = 0; f < 7; f++) begin
               if (got[f] !== want[f]) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("contact %0d, %s: expected %0d, got %0d", contacts_checked,
                              field_label[f], $signed(want[f]), $signed(got[f]));
                  end
               end
            end
         end
      end
   end

   // Ends a run that stops making progress on every port.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      bit           last_was_write;
      int           mode;
      int           shift;
      int           eps;
      pos_type      x;
      pos_type      y;
      pos_type      z;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      for (int i = 0; i < 8; i++) begin
         csr_shadow[i] = '0;
      end
      csr_shadow[REG_EPSILON] = 1;

      // Registers at reset: zero poses and normal give distance zero, below the
      // reset epsilon of one, so every vertex touches with all fields zero.
      add_typed(0, 0, 0, 1'b1, '0);
      add_typed(POS_MAX, POS_MAX, POS_MAX, 1'b1, '0);
      add_typed(POS_MIN, POS_MIN, POS_MIN, 1'b1, '0);
      add_typed(POS_MAX, POS_MIN, -1, 1'b1, '0);

      // Identity plane with normal along z, shifted mesh, zero epsilon: only
      // vertices strictly below the plane touch, and they project to z = 0.
      add_write(REG_PLANE_ROW0, make_row(UNIT, 0, 0, 0));
      add_write(REG_PLANE_ROW1, make_row(0, UNIT, 0, 0));
      add_write(REG_PLANE_ROW2, make_row(0, 0, UNIT, 0));
      add_write(REG_NORMAL, make_row(0, 0, UNIT, 0));
      add_write(REG_MESH_ROW0, make_row(UNIT, 0, 0, 100));
      add_write(REG_MESH_ROW1, make_row(0, UNIT, 0, 200));
      add_write(REG_MESH_ROW2, make_row(0, 0, UNIT, 300));
      add_write(REG_EPSILON, 0);
      add_typed('h10000, 'h20000, 'h30000, 1'b0, '0);
      add_typed(5, -7, 0, 1'b0, '0);
      add_typed('h10000, -'h20000, -'h8000, 1'b1,
                contact_of('h8000, 'h10000 + 100, -'h20000 + 200, -'h8000 + 300,
                           'h10000, -'h20000, 0));
      add_typed(POS_MAX, POS_MAX, POS_MAX, 1'b0, '0);
      add_typed(POS_MIN, POS_MIN, POS_MIN, 1'b1,
                contact_of(POS_MAX, POS_MIN + 100, POS_MIN + 200, POS_MIN + 300,
                           POS_MIN, POS_MIN, 0));
      add_typed(0, 0, -1, 1'b1, contact_of(1, 100, 200, 299, 0, 0, 0));

      // Every entry at an extreme and the widest epsilon: saturation everywhere.
      for (int i = 0; i < 3; i++) begin
         add_write(reg_idx_type'(REG_PLANE_ROW0 + i), make_row(ROT_MIN, ROT_MIN, ROT_MIN,
                                                               POS_MIN));
         add_write(reg_idx_type'(REG_MESH_ROW0 + i), make_row(ROT_MAX, ROT_MAX, ROT_MAX,
                                                              POS_MAX));
      end
      add_write(REG_NORMAL, make_row(ROT_MAX, ROT_MAX, ROT_MAX, POS_MAX));
      add_write(REG_EPSILON, (1 << EPS_W) - 1);
      add_vertex(POS_MAX, POS_MAX, POS_MAX);
      add_vertex(POS_MIN, POS_MIN, POS_MIN);
      add_vertex(POS_MAX, POS_MIN, POS_MAX);
      add_vertex(0, 0, 0);
      add_vertex(-1, -1, -1);
      add_vertex(1, 0, -1);

      // Skewed rotations and a normal that is not of unit length.
      add_write(REG_PLANE_ROW0, make_row(3000, -5000, 100, 'h1234));
      add_write(REG_PLANE_ROW1, make_row(-4096, 2048, 7000, -'h20000));
      add_write(REG_PLANE_ROW2, make_row(123, ROT_MAX, ROT_MIN, 'h3FFFF));
      add_write(REG_NORMAL, make_row(1000, 2000, -3000, -'h40000));
      add_write(REG_MESH_ROW0, make_row(ROT_MIN, 0, UNIT, -5));
      add_write(REG_MESH_ROW1, make_row(0, -UNIT, 0, POS_MAX));
      add_write(REG_MESH_ROW2, make_row(4095, 4095, 4095, POS_MIN));
      add_write(REG_EPSILON, 'h8000);
      add_vertex('h12345, -'h54321, 'h0ABCD);
      add_vertex(-'h100000, 'h0FFFFF, 7);
      add_vertex(1, -1, 1);
      add_vertex(POS_MAX, 0, POS_MIN);
      add_vertex(-'h33333, -'h44444, 'h55555);
      add_vertex('h2AAAA, 'h15555, -'h2AAAA);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      last_was_write = 1'b0;
      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         if (row.is_write) begin
            if (!last_was_write) begin
               settle_pipeline();
            end
            write_csr(row.idx, row.value);
         end else begin
            if (last_was_write) begin
               release_csr();
            end
            offer_vertex(row.vx, row.vy, row.vz);
            if (!row.typed) begin
               expect_predicted(row.vx, row.vy, row.vz);
            end else if (row.hit) begin
               expected_contacts.push_back(row.want);
            end
         end
         last_was_write = row.is_write;
      end

      // Random phases, each with a fresh register setting.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle_pipeline();
         mode  = phase % 3;
         shift = $urandom_range(0, 2);
         for (int i = 0; i < 3; i++) begin
            write_csr(reg_idx_type'(REG_PLANE_ROW0 + i), random_pose_row(mode, (i + shift) % 3));
         end
         write_csr(REG_NORMAL, random_pose_row(mode, $urandom_range(0, 2)));
         shift = $urandom_range(0, 2);
         for (int i = 0; i < 3; i++) begin
            write_csr(reg_idx_type'(REG_MESH_ROW0 + i), random_pose_row(mode, (i + shift) % 3));
         end
         if (phase == 0) begin
            eps = 0;
         end else if (phase == 1) begin
            eps = (1 << EPS_W) - 1;
         end else if (phase % 2 == 1) begin
            eps = $urandom_range(0, (1 << EPS_W) - 1);
         end else begin
            eps = $urandom_range(0, 1 << 16);
         end
         write_csr(REG_EPSILON, eps);
         release_csr();
         sender_calm   = (phase % 4 == 1) || (phase % 4 == 3);
         receiver_calm = (phase % 4 == 2) || (phase % 4 == 3);
         repeat (PHASE_ITEMS) begin
            x = pick_coord();
            y = pick_coord();
            z = pick_coord();
            offer_vertex(x, y, z);
            expect_predicted(x, y, z);
         end
      end

      settle_pipeline();
      $display("covered %0d vertices, %0d of them directed; %0d contacts checked",
               vertices_sent, directed_rows.size() - csr_writes + PHASES * 8, contacts_checked);
      $display("%0d register writes: reset state, identity, extremes, skewed and %0d random",
               csr_writes, PHASES);
      if (mismatches == 0 && expected_contacts.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d contacts missing", mismatches, expected_contacts.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule
